FILE: sv/mhti_pkg.sv
`timescale 1ns / 1ps

package mhti_pkg;

  localparam int unsigned MacByteW     = 8;
  localparam int unsigned CrcW         = 32;
  localparam int unsigned HashIdxW     = 6;
  localparam int unsigned TableW       = 64;
  localparam int unsigned AddrBytesDef = 6;

  localparam logic [CrcW-1:0] CrcInit  = 32'hFFFF_FFFF;
  localparam logic [CrcW-1:0] CrcPoly  = 32'h04C1_1DB7;
  localparam int unsigned     IdxShift = 23;

  typedef logic [MacByteW-1:0] mac_byte_t;
  typedef logic [CrcW-1:0]     crc_t;
  typedef logic [HashIdxW-1:0] hash_idx_t;
  typedef logic [TableW-1:0]   table_t;

  // Left-shifting CRC, data bits fed LSB first.
  function automatic crc_t crc_feed_byte(crc_t crc_in, mac_byte_t data);
    crc_t crc;
    crc = crc_in;
    for (int k = 0; k < MacByteW; k++) begin
      if (crc[CrcW-1] ^ data[k]) begin
        crc = {crc[CrcW-2:0], 1'b0} ^ CrcPoly;
      end else begin
        crc = {crc[CrcW-2:0], 1'b0};
      end
    end
    return crc;
  endfunction

  function automatic hash_idx_t crc_to_index(crc_t crc);
    return crc[IdxShift +: HashIdxW];
  endfunction

endpackage

FILE: sv/mhti_in_if.sv
`timescale 1ns / 1ps

interface mhti_in_if import mhti_pkg::*; ();
  logic      valid;
  logic      ready;
  mac_byte_t mac_byte;

  modport source (output valid, output mac_byte, input ready);
  modport sink   (input valid, input mac_byte, output ready);
endinterface

FILE: sv/mhti_out_if.sv
`timescale 1ns / 1ps

interface mhti_out_if import mhti_pkg::*; ();
  logic      valid;
  logic      ready;
  hash_idx_t hash_index;
  table_t    table_bits;

  modport source (output valid, output hash_index, output table_bits, input ready);
  modport sink   (input valid, input hash_index, input table_bits, output ready);
endinterface

FILE: sv/multicast_hash_table_insert.sv
`timescale 1ns / 1ps
// A byte accepted from in_bus lands in the input register; the last byte of an
// address then loads the result register, where its beat waits until out_bus takes it.
// Throughput: one byte per cycle, set by the byte-wide CRC update between the input
// register and the CRC/result registers. Input stalls only when the last byte of an
// address meets a result beat that has not been taken.
// Reset (rst_n low, synchronous): CRC to all ones, byte count and hash table to zero,
// no beat in flight.

module multicast_hash_table_insert import mhti_pkg::*; #(
  parameter int unsigned ADDRESS_BYTES = AddrBytesDef
) (
  input  logic clk,
  input  logic rst_n,
  mhti_in_if.sink    in_bus,
  mhti_out_if.source out_bus
);

  localparam int unsigned PosW = (ADDRESS_BYTES > 1) ? $clog2(ADDRESS_BYTES) : 1;
  localparam logic [PosW-1:0] LastPos = PosW'(ADDRESS_BYTES - 1);

  // input register
  logic      s1_valid_r;
  mac_byte_t s1_byte_r;

  // running state
  crc_t            crc_r,   crc_nxt;
  logic [PosW-1:0] pos_r,   pos_nxt;
  table_t          table_r, table_nxt;

  // result register
  logic      out_valid_r;
  hash_idx_t out_idx_r;
  table_t    out_table_r;

  logic      is_last;
  logic      out_free;
  logic      s1_fire;
  logic      emit;
  crc_t      crc_upd;
  hash_idx_t idx;

  always_comb begin
    crc_upd  = crc_feed_byte(crc_r, s1_byte_r);
    idx      = crc_to_index(crc_upd);
    is_last  = (pos_r == LastPos);
    out_free = !out_valid_r || out_bus.ready;
    // only the last byte needs room in the result register
    s1_fire  = s1_valid_r && (!is_last || out_free);
    emit     = s1_fire && is_last;

    crc_nxt   = crc_r;
    pos_nxt   = pos_r;
    table_nxt = table_r;
    if (s1_fire) begin
      if (is_last) begin
        crc_nxt   = CrcInit;
        pos_nxt   = '0;
        table_nxt = table_r | (table_t'(1) << idx);
      end else begin
        crc_nxt = crc_upd;
        pos_nxt = pos_r + PosW'(1);
      end
    end
  end

  assign in_bus.ready       = !s1_valid_r || s1_fire;
  assign out_bus.valid      = out_valid_r;
  assign out_bus.hash_index = out_idx_r;
  assign out_bus.table_bits = out_table_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      crc_r       <= CrcInit;
      pos_r       <= '0;
      table_r     <= '0;
    end else begin
      if (in_bus.ready) begin
        s1_valid_r <= in_bus.valid;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
      crc_r   <= crc_nxt;
      pos_r   <= pos_nxt;
      table_r <= table_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      s1_byte_r <= in_bus.mac_byte;
    end
    if (emit) begin
      out_idx_r   <= idx;
      out_table_r <= table_nxt;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |-> pos_r <= LastPos)
    else $error("byte count past last byte");

  a_table_grows: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> (($past(table_r) & ~table_r) == '0))
    else $error("hash table lost a bit");

  a_out_bit_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_table_r[out_idx_r])
    else $error("result table misses its own index bit");

  a_out_table_live: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_table_r == table_r)
    else $error("table changed while result beat pending");

endmodule
